@@ src/mpc_pkg.sv @@
// Package for the per-thread message port core: sizes, operation and status
// codes, and the structs passed between the port table and the top level.
// No dependencies.
`timescale 1ns / 1ps

package mpc_pkg;

  localparam int THREADS       = 8;
  localparam int PORT_DEPTH    = 16;
  localparam int PAYLOAD_WIDTH = 32;

  localparam int TID_W   = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int PTR_W   = (PORT_DEPTH > 1) ? $clog2(PORT_DEPTH) : 1;
  localparam int FILL_W  = $clog2(PORT_DEPTH + 1);
  localparam int ENTRIES = THREADS * PORT_DEPTH;
  localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OWNER_W = 3;
  localparam int ENTRY_W = PAYLOAD_WIDTH + OWNER_W;

  typedef enum logic [1:0] {
    OP_SEND    = 2'd0,
    OP_RECEIVE = 2'd1,
    OP_FLUSH   = 2'd2,
    OP_COUNT   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic               we;
    logic               re;
    logic [ADDR_W-1:0]  addr;
    logic [ENTRY_W-1:0] wdata;
  } ram_req_t;

  typedef struct packed {
    status_t    status;
    logic [4:0] pending;
    logic       hit;
  } result_t;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (int'(p) == PORT_DEPTH - 1) ? '0 : p + PTR_W'(1);
  endfunction

endpackage

@@ src/mpc_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module mpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                      wdata,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

@@ src/mpc_ctrl.sv @@
// Port table: read/write pointers and fill count of each thread's ring,
// decode of one operation into a store access and a result. Uses mpc_pkg.
`timescale 1ns / 1ps

module mpc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  mpc_pkg::op_t       op,
  input  logic [2:0]         thread,
  input  logic [2:0]         sender,
  input  logic [31:0]        payload,
  output mpc_pkg::ram_req_t  ram_req,
  output mpc_pkg::result_t   result
);
  import mpc_pkg::*;

  logic [PTR_W-1:0]  read_ptr  [THREADS];
  logic [PTR_W-1:0]  write_ptr [THREADS];
  logic [FILL_W-1:0] fill      [THREADS];

  logic              thread_ok;
  logic [TID_W-1:0]  tidx;
  logic [PTR_W-1:0]  rp, wp, rp_next, wp_next;
  logic [FILL_W-1:0] f, fill_next;
  logic [ADDR_W-1:0] base;

  assign thread_ok = int'(thread) < THREADS;
  assign tidx      = TID_W'(thread);
  assign rp        = read_ptr[tidx];
  assign wp        = write_ptr[tidx];
  assign f         = fill[tidx];
  assign base      = ADDR_W'(int'(tidx) * PORT_DEPTH);

  always_comb begin
    rp_next        = rp;
    wp_next        = wp;
    fill_next      = f;
    ram_req.we     = 1'b0;
    ram_req.re     = 1'b0;
    ram_req.addr   = base;
    ram_req.wdata  = {PAYLOAD_WIDTH'(payload), sender};
    result.status  = ST_OK;
    result.hit     = 1'b0;
    if (!thread_ok) begin
      if (op == OP_SEND) begin
        result.status = ST_FULL;
      end else if (op == OP_RECEIVE) begin
        result.status = ST_EMPTY;
      end
    end else begin
      case (op)
        OP_SEND: begin
          if (f == FILL_W'(PORT_DEPTH)) begin
            result.status = ST_FULL;
          end else begin
            ram_req.we   = go;
            ram_req.addr = base + ADDR_W'(wp);
            wp_next      = ring_next(wp);
            fill_next    = f + FILL_W'(1);
          end
        end
        OP_RECEIVE: begin
          if (f == '0) begin
            result.status = ST_EMPTY;
          end else begin
            ram_req.re   = go;
            ram_req.addr = base + ADDR_W'(rp);
            result.hit   = 1'b1;
            rp_next      = ring_next(rp);
            fill_next    = f - FILL_W'(1);
          end
        end
        OP_FLUSH: begin
          rp_next   = '0;
          wp_next   = '0;
          fill_next = '0;
        end
        default: ;
      endcase
    end
    result.pending = thread_ok ? 5'(fill_next) : 5'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < THREADS; i++) begin
        read_ptr[i]  <= '0;
        write_ptr[i] <= '0;
        fill[i]      <= '0;
      end
    end else if (go && thread_ok) begin
      read_ptr[tidx]  <= rp_next;
      write_ptr[tidx] <= wp_next;
      fill[tidx]      <= fill_next;
    end
  end

endmodule

@@ src/per_thread_message_port_core.sv @@
// Top level of the per-thread message port core: input register, port table,
// message store RAM and result register. Uses mpc_pkg, mpc_ctrl, mpc_ram.
// An accepted beat goes through the input register, then the result register; rsp_stall holds both.
// Throughput: one beat per cycle while rsp_stall is low; the store RAM takes one access per cycle.
// Reset: every port empty, pointers at zero; stored messages are not cleared.
`timescale 1ns / 1ps

module per_thread_message_port_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  op,
  input  logic [2:0]  thread,
  input  logic [2:0]  sender,
  input  logic [31:0] payload,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [1:0]  status,
  output logic [31:0] data_out,
  output logic [2:0]  owner_out,
  output logic [4:0]  pending
);
  import mpc_pkg::*;

  logic         s1_valid;
  op_t          s1_op;
  logic [2:0]   s1_thread;
  logic [2:0]   s1_sender;
  logic [31:0]  s1_payload;
  logic         s2_valid;
  result_t      s2_result;

  logic         advance;
  logic         accept;
  ram_req_t     ram_req;
  result_t      result;
  logic [ENTRY_W-1:0] rdata;

  assign advance   = !s2_valid || !rsp_stall;
  assign req_stall = s1_valid && !advance;
  assign accept    = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op      <= op_t'(op);
      s1_thread  <= thread;
      s1_sender  <= sender;
      s1_payload <= payload;
    end
  end

  mpc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .go      (s1_valid && advance),
    .op      (s1_op),
    .thread  (s1_thread),
    .sender  (s1_sender),
    .payload (s1_payload),
    .ram_req (ram_req),
    .result  (result)
  );

  mpc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (ram_req.we),
    .re    (ram_req.re),
    .addr  (ram_req.addr),
    .wdata (ram_req.wdata),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_result <= result;
    end
  end

  // read data is held by the RAM until the next read, which only happens on advance
  assign rsp_valid = s2_valid;
  assign status    = s2_result.status;
  assign pending   = s2_result.pending;
  assign data_out  = s2_result.hit ? 32'(rdata[ENTRY_W-1:OWNER_W]) : 32'd0;
  assign owner_out = s2_result.hit ? rdata[OWNER_W-1:0] : 3'd0;

endmodule
